// ===== src/dhcprp_pkg.sv =====
`default_nettype none

package dhcprp_pkg;

  // input word: one payload byte or a restart command
  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } dhcp_in_t;

  // result word: event, client state and the captured addresses
  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  client_state;
    logic [31:0] offered_ip;
    logic [31:0] net_mask;
    logic [31:0] router_addr;
    logic [31:0] dns_addr;
    logic [31:0] time_addr;
    logic [31:0] server_addr;
  } dhcp_out_t;

  // request kinds
  localparam logic ReqByte    = 1'b0;
  localparam logic ReqRestart = 1'b1;

  // result event codes
  localparam logic [1:0] EvIgnored = 2'd0;
  localparam logic [1:0] EvOffer   = 2'd1;
  localparam logic [1:0] EvAck     = 2'd2;
  localparam logic [1:0] EvRestart = 2'd3;

  // client state codes as reported
  localparam logic [1:0] CsClosed  = 2'd0;
  localparam logic [1:0] CsDisc    = 2'd1;
  localparam logic [1:0] CsReq     = 2'd2;
  localparam logic [1:0] CsAcked   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgXid     = 2'd0;
  localparam logic [1:0] CfgMac     = 2'd1;
  localparam logic [1:0] CfgTimeOpt = 2'd2;

  // header constants
  localparam logic [7:0] OpBootReply = 8'd2;
  localparam logic [7:0] HtypeEth    = 8'd1;
  localparam logic [7:0] HlenEth     = 8'd6;
  localparam logic [7:0] CookieByte [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

  // option codes
  localparam logic [7:0] OptPad     = 8'd0;
  localparam logic [7:0] OptMask    = 8'd1;
  localparam logic [7:0] OptRouter  = 8'd3;
  localparam logic [7:0] OptDns     = 8'd6;
  localparam logic [7:0] OptMsgType = 8'd53;
  localparam logic [7:0] OptServer  = 8'd54;
  localparam logic [7:0] OptEnd     = 8'hff;
  localparam logic [7:0] OptTimeRst = 8'd42;
  localparam logic [7:0] AddrLen    = 8'd4;
  localparam logic [7:0] TypeLen    = 8'd1;

  // message types
  localparam logic [7:0] MsgOffer = 8'd2;
  localparam logic [7:0] MsgAck   = 8'd5;

  typedef enum logic [3:0] {
    PhClosed = 4'b0001,
    PhDisc   = 4'b0010,
    PhReq    = 4'b0100,
    PhAcked  = 4'b1000
  } phase_e;

  typedef enum logic [3:0] {
    TmNone    = 4'b0001,
    TmOffer   = 4'b0010,
    TmAck     = 4'b0100,
    TmPending = 4'b1000
  } type_match_e;

  typedef enum logic [3:0] {
    OpCode  = 4'b0001,
    OpLen   = 4'b0010,
    OpValue = 4'b0100,
    OpEnd   = 4'b1000
  } opt_phase_e;

endpackage

`default_nettype wire

// ===== src/dhcp_reply_parser.sv =====
`default_nettype none

// DHCP client reply parser. A word is either one byte of a DHCP reply (starting at
// the op field) or a restart command. The header is checked at its standard offsets
// (op, htype, hlen, xid, nonzero yiaddr, chaddr, magic cookie) and the first option
// must be message type. While discovering, an offer walks its options up to END and
// captures yiaddr plus the four-byte subnet mask, router, DNS, time server and server
// id options, then the client goes to requesting; while requesting, an ack moves it to
// acknowledged. A result word comes out for every final byte and every restart, none
// for other bytes. Throughput is one word per clock while the output is not stalled:
// each byte is handled by one pass of compare and shift logic between the input
// register and the result register. in_stall_o follows out_stall_i in the same
// cycle while both registers are full. Configuration writes are always ready and
// must only happen while the block is idle.
module dhcp_reply_parser #(
  parameter int unsigned MaxMessageBytes = 1024
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  dhcprp_pkg::dhcp_in_t  in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output dhcprp_pkg::dhcp_out_t out_word_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [1:0]             cfg_index_i,
  input  wire [47:0]            cfg_data_i
);
  import dhcprp_pkg::*;

  // offset counter saturates at the message limit
  localparam int unsigned OffW = $clog2(MaxMessageBytes + 1);
  localparam logic [OffW-1:0] OffLimit = OffW'(MaxMessageBytes);

  // configuration registers
  logic [31:0] xid_q;
  logic [47:0] mac_q;
  logic [7:0]  time_code_q;

  // input register
  logic     s1_valid_q;
  dhcp_in_t s1_word_q;
  logic     advance;

  // result register
  logic      out_valid_q;
  dhcp_out_t out_word_q, res_word;
  logic      has_res;

  // parser state
  phase_e      phase_q, phase_d;
  logic [OffW-1:0] off_q, off_d;
  logic        hg_q, hg_d;
  type_match_e tm_q, tm_d, tm_new;
  opt_phase_e  op_q, op_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  left_q, left_d, left_new;
  logic [7:0]  len_q, len_d;
  logic [31:0] vs_q, vs_d, vs_new;
  logic [31:0] ip_q, ip_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] router_q, router_d;
  logic [31:0] dns_q, dns_d;
  logic [31:0] time_q, time_d;
  logic [31:0] server_q, server_d;

  logic [7:0]  b;
  logic        offer_walk;
  logic [1:0]  xid_sel;
  logic [2:0]  mac_sel;
  logic [1:0]  cookie_sel;
  logic [1:0]  ev;
  logic [1:0]  cs_code;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q       <= '0;
      mac_q       <= '0;
      time_code_q <= OptTimeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgXid:     xid_q       <= cfg_data_i[31:0];
        CfgMac:     mac_q       <= cfg_data_i;
        CfgTimeOpt: time_code_q <= cfg_data_i[7:0];
        default:    ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register moves on whenever the result register has room
  // ---------------------------------------------------------------------------
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_word_q <= in_word_i;
    end
  end

  // ---------------------------------------------------------------------------
  // byte step: header checks, type option and option walk
  // ---------------------------------------------------------------------------
  assign b          = s1_word_q.data_byte;
  assign offer_walk = hg_q && (tm_q == TmOffer) && (phase_q == PhDisc);
  assign xid_sel    = 2'd3 - off_q[1:0];           // xid is big-endian
  assign mac_sel    = 3'(off_q - OffW'(28));
  assign cookie_sel = 2'(off_q - OffW'(236));
  assign vs_new     = {b, vs_q[31:8]};               // first byte ends up lowest
  assign left_new   = left_q - 8'd1;

  always_comb begin
    tm_new = tm_q;
    if (tm_q == TmPending) begin
      if (b == MsgOffer)    tm_new = TmOffer;
      else if (b == MsgAck) tm_new = TmAck;
      else                  tm_new = TmNone;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    off_d    = off_q;
    hg_d     = hg_q;
    tm_d     = tm_q;
    op_d     = op_q;
    code_d   = code_q;
    left_d   = left_q;
    len_d    = len_q;
    vs_d     = vs_q;
    ip_d     = ip_q;
    mask_d   = mask_q;
    router_d = router_q;
    dns_d    = dns_q;
    time_d   = time_q;
    server_d = server_q;
    has_res  = 1'b0;
    ev       = EvIgnored;

    if (s1_word_q.req_type == ReqRestart) begin
      phase_d  = PhDisc;
      ip_d     = '0;
      mask_d   = '0;
      router_d = '0;
      dns_d    = '0;
      time_d   = '0;
      server_d = '0;
      has_res  = 1'b1;
      ev       = EvRestart;
    end else begin
      if (off_q < OffLimit) begin
        off_d = off_q + OffW'(1);
        if (off_q == OffW'(0)) begin
          if (b != OpBootReply) hg_d = 1'b0;
        end else if (off_q == OffW'(1)) begin
          if (b != HtypeEth) hg_d = 1'b0;
        end else if (off_q == OffW'(2)) begin
          if (b != HlenEth) hg_d = 1'b0;
        end else if (off_q >= OffW'(4) && off_q <= OffW'(7)) begin
          if (b != xid_q[{xid_sel, 3'b000} +: 8]) hg_d = 1'b0;
        end else if (off_q >= OffW'(16) && off_q <= OffW'(19)) begin
          // yiaddr collects in the shift register until the type option
          vs_d = vs_new;
          if (off_q == OffW'(19) && vs_new == '0) hg_d = 1'b0;
        end else if (off_q >= OffW'(28) && off_q <= OffW'(33)) begin
          if (b != mac_q[{mac_sel, 3'b000} +: 8]) hg_d = 1'b0;
        end else if (off_q >= OffW'(236) && off_q <= OffW'(239)) begin
          if (b != CookieByte[cookie_sel]) hg_d = 1'b0;
        end else if (off_q == OffW'(240)) begin
          tm_d = (b == OptMsgType) ? TmPending : TmNone;
        end else if (off_q == OffW'(241)) begin
          if (b != TypeLen) tm_d = TmNone;
        end else if (off_q == OffW'(242)) begin
          tm_d = tm_new;
          if (hg_q && tm_new == TmOffer && phase_q == PhDisc) ip_d = vs_q;
        end else if (off_q > OffW'(242) && offer_walk) begin
          unique case (op_q)
            OpCode: begin
              if (b == OptEnd) begin
                op_d = OpEnd;
              end else if (b != OptPad) begin
                code_d = b;
                op_d   = OpLen;
              end
            end
            OpLen: begin
              len_d  = b;
              left_d = b;
              vs_d   = '0;
              op_d   = (b == 8'd0) ? OpCode : OpValue;
            end
            OpValue: begin
              vs_d   = vs_new;
              left_d = left_new;
              if (left_new == 8'd0) begin
                op_d = OpCode;
                // only four-byte values are kept; colliding codes fill every match
                if (len_q == AddrLen) begin
                  if (code_q == OptMask)     mask_d   = vs_new;
                  if (code_q == OptRouter)   router_d = vs_new;
                  if (code_q == OptDns)      dns_d    = vs_new;
                  if (code_q == time_code_q) time_d   = vs_new;
                  if (code_q == OptServer)   server_d = vs_new;
                end
              end
            end
            OpEnd:   ;
            default: ;
          endcase
        end
      end

      if (s1_word_q.last_byte) begin
        has_res = 1'b1;
        if (hg_d && tm_d == TmOffer && phase_q == PhDisc) begin
          phase_d = PhReq;
          ev      = EvOffer;
        end else if (hg_d && tm_d == TmAck && phase_q == PhReq) begin
          phase_d = PhAcked;
          ev      = EvAck;
        end
      end
    end

    // a restart or the end of a message starts the next message fresh
    if (s1_word_q.req_type == ReqRestart || s1_word_q.last_byte) begin
      off_d  = '0;
      hg_d   = 1'b1;
      tm_d   = TmNone;
      op_d   = OpCode;
      code_d = '0;
      left_d = '0;
      len_d  = '0;
      vs_d   = '0;
    end
  end

  // reported client state
  always_comb begin
    unique case (phase_d)
      PhClosed: cs_code = CsClosed;
      PhDisc:   cs_code = CsDisc;
      PhReq:    cs_code = CsReq;
      PhAcked:  cs_code = CsAcked;
      default:  cs_code = CsClosed;
    endcase
  end

  always_comb begin
    res_word.event_res    = ev;
    res_word.client_state = cs_code;
    res_word.offered_ip   = ip_d;
    res_word.net_mask     = mask_d;
    res_word.router_addr  = router_d;
    res_word.dns_addr     = dns_d;
    res_word.time_addr    = time_d;
    res_word.server_addr  = server_d;
  end

  // ---------------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhClosed;
      off_q    <= '0;
      hg_q     <= 1'b1;
      tm_q     <= TmNone;
      op_q     <= OpCode;
      code_q   <= '0;
      left_q   <= '0;
      len_q    <= '0;
      vs_q     <= '0;
      ip_q     <= '0;
      mask_q   <= '0;
      router_q <= '0;
      dns_q    <= '0;
      time_q   <= '0;
      server_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      hg_q     <= hg_d;
      tm_q     <= tm_d;
      op_q     <= op_d;
      code_q   <= code_d;
      left_q   <= left_d;
      len_q    <= len_d;
      vs_q     <= vs_d;
      ip_q     <= ip_d;
      mask_q   <= mask_d;
      router_q <= router_d;
      dns_q    <= dns_d;
      time_q   <= time_d;
      server_q <= server_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && has_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      out_word_q <= res_word;
    end
  end

endmodule

`default_nettype wire
